// File: hw/rtl/wmdt_pkg.sv
`default_nettype none
package wmdt_pkg;

	// Sizing of the detection window and of the item fields.
	localparam int WINDOW_DEPTH = 64;
	localparam int COORD_BITS   = 12;
	localparam int KEY_BITS     = 11;

	localparam int WIN_AW  = $clog2(WINDOW_DEPTH);
	localparam int CNT_W   = WIN_AW + 1;
	localparam int PROD_W  = CNT_W + 9;
	localparam int RECT_W  = 4 * COORD_BITS;
	localparam int CSUM_W  = COORD_BITS + 2;
	localparam int IN_W    = ((KEY_BITS + RECT_W + 7) / 8) * 8;
	localparam int OUT_W   = 64;
	localparam int APB_AW  = 5;

	localparam logic [13:0] CENTRE_MAX = 14'd16383;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_WTICKS = 3'd1;
	localparam logic [2:0] REG_PASS   = 3'd2;
	localparam logic [2:0] REG_SIZE   = 3'd3;
	localparam logic [2:0] REG_LOST   = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_MOVED  = 2'd0;
	localparam logic [1:0] ST_INSIDE = 2'd1;
	localparam logic [1:0] ST_NOTRK  = 2'd2;
	localparam logic [1:0] ST_LOST   = 2'd3;

	typedef enum logic {
		OP_DET  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [KEY_BITS-1:0]  key;
		logic [RECT_W-1:0]    rect;
	} item_t;

	typedef struct packed {
		logic        enable;
		logic [12:0] wticks;
		logic [8:0]  pass;
		logic [7:0]  size;
		logic [15:0] lost;
	} cfg_t;

	typedef struct packed {
		logic       clear;
		logic       resize;
		logic [7:0] new_size;
	} cfg_evt_t;

endpackage
`default_nettype wire

// File: hw/rtl/wmdt_ram.sv
`default_nettype none
module wmdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/wmdt_front.sv
`default_nettype none
module wmdt_front
	import wmdt_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [IN_W-1:0] s_tdata,
	input  wire logic            s_tuser,
	input  wire logic            enable,
	output logic                 q_valid,
	output item_t                q_item,
	input  wire logic            q_pop
);

	item_t       ent_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	logic        acc;
	logic        keep;
	item_t       nitem;

	// Classify the incoming request; detections while disabled are dropped.
	always_comb begin
		nitem.op   = s_tuser ? OP_TICK : OP_DET;
		nitem.key  = s_tdata[KEY_BITS-1:0];
		nitem.rect = s_tdata[KEY_BITS +: RECT_W];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign acc      = s_tvalid && s_tready;
	assign keep     = acc && (s_tuser || enable);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	// Two-entry queue between the front and the back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (keep) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(keep) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			ent_q[wp_q] <= nitem;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/wmdt_back.sv
`default_nettype none
module wmdt_back
	import wmdt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire item_t            q_item,
	output logic                  q_pop,
	input  wire cfg_t             cfg,
	input  wire cfg_evt_t         evt,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LDI  = 6'b000010,
		S_LDW  = 6'b000100,
		S_CNT  = 6'b001000,
		S_DEC  = 6'b010000,
		S_RW   = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         fill_q;
	logic [15:0]              elapsed_q;
	logic signed [14:0]       box_l_q;
	logic signed [14:0]       box_t_q;
	logic                     box_v_q;
	logic [15:0]              cd_q;
	logic                     armed_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         i_q;
	logic [WIN_AW-1:0]        j_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [WIN_AW-1:0]        lastj_q;
	logic [KEY_BITS-1:0]      key_i_q;
	logic [CNT_W-1:0]         best_cnt_q;
	logic [KEY_BITS-1:0]      best_key_q;
	logic [WIN_AW-1:0]        best_last_q;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;

	logic                     wr_en;
	logic [WIN_AW-1:0]        key_raddr;
	logic [KEY_BITS-1:0]      key_rdata;
	logic [RECT_W-1:0]        rect_rdata;
	logic                     eq;
	logic                     last_j;
	logic [CNT_W-1:0]         c_fin;
	logic [WIN_AW-1:0]        lj;
	logic                     better;
	logic                     room;
	logic [CNT_W-1:0]         n_fill;
	logic [15:0]              cd_next;
	logic                     fail;
	logic [PROD_W-1:0]        lhs;
	logic [PROD_W-1:0]        rhs;
	logic [CSUM_W-1:0]        sx;
	logic [CSUM_W-1:0]        sy;
	logic [13:0]              cx;
	logic [13:0]              cy;
	logic signed [16:0]       scx;
	logic signed [16:0]       scy;
	logic signed [16:0]       side;
	logic                     in_box;
	logic signed [14:0]       nbx;
	logic signed [14:0]       nby;

	assign q_pop  = (state_q == S_IDLE) && q_valid && !out_valid_q;
	assign room   = (fill_q < CNT_W'(WINDOW_DEPTH));
	assign wr_en  = q_pop && (q_item.op == OP_DET) && room;
	assign n_fill = fill_q + CNT_W'(room);

	// Key address per scan step.
	always_comb begin
		unique case (state_q)
			S_LDI:   key_raddr = i_q[WIN_AW-1:0];
			S_CNT:   key_raddr = j_q + WIN_AW'(1);
			default: key_raddr = '0;
		endcase
	end

	wmdt_ram #(.WIDTH(KEY_BITS), .DEPTH(WINDOW_DEPTH)) u_keys (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q[WIN_AW-1:0]),
		.wdata (q_item.key),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	wmdt_ram #(.WIDTH(RECT_W), .DEPTH(WINDOW_DEPTH)) u_rects (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q[WIN_AW-1:0]),
		.wdata (q_item.rect),
		.raddr (best_last_q),
		.rdata (rect_rdata)
	);

	// Count step: compare one stored key with the key under test.
	assign eq     = (key_rdata == key_i_q);
	assign last_j = (j_q == WIN_AW'(n_q - CNT_W'(1)));
	assign c_fin  = cnt_q + CNT_W'(eq);
	assign lj     = eq ? j_q : lastj_q;
	assign better = (c_fin > best_cnt_q) ||
		((c_fin == best_cnt_q) && ($signed(key_i_q) < $signed(best_key_q)));

	// Share test and the no-face key.
	assign lhs  = PROD_W'({best_cnt_q, 8'd0});
	assign rhs  = PROD_W'(cfg.pass) * PROD_W'(n_q);
	assign fail = (best_key_q == '1) || (lhs < rhs);

	// Centre of the winning rectangle and the dead-zone test.
	assign sx = CSUM_W'({rect_rdata[0 +: COORD_BITS], 1'b0}) +
		CSUM_W'(rect_rdata[2*COORD_BITS +: COORD_BITS]);
	assign sy = CSUM_W'({rect_rdata[COORD_BITS +: COORD_BITS], 1'b0}) +
		CSUM_W'(rect_rdata[3*COORD_BITS +: COORD_BITS]);
	assign cx = (32'(sx) > 32'(CENTRE_MAX)) ? CENTRE_MAX : 14'(sx);
	assign cy = (32'(sy) > 32'(CENTRE_MAX)) ? CENTRE_MAX : 14'(sy);
	assign scx  = $signed({3'b000, cx});
	assign scy  = $signed({3'b000, cy});
	assign side = box_v_q ? $signed({8'd0, cfg.size, 1'b0}) : 17'sd0;
	assign in_box = (scx > 17'(box_l_q)) && (scx < 17'(box_l_q) + side) &&
		(scy > 17'(box_t_q)) && (scy < 17'(box_t_q) + side);
	assign nbx = 15'(scx - $signed({9'd0, cfg.size}));
	assign nby = 15'(scy - $signed({9'd0, cfg.size}));

	assign cd_next = (cd_q != 16'd0) ? cd_q - 16'd1 : cd_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Sequencer and tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			elapsed_q   <= '0;
			box_l_q     <= '0;
			box_t_q     <= '0;
			box_v_q     <= 1'b0;
			cd_q        <= '0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (evt.clear) begin
				fill_q    <= '0;
				elapsed_q <= '0;
				box_l_q   <= '0;
				box_t_q   <= '0;
				box_v_q   <= 1'b0;
			end
			if (evt.resize && box_v_q) begin
				box_l_q <= box_l_q + 15'($signed({1'b0, cfg.size}) -
					$signed({1'b0, evt.new_size}));
				box_t_q <= box_t_q + 15'($signed({1'b0, cfg.size}) -
					$signed({1'b0, evt.new_size}));
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && q_item.op == OP_TICK) begin
						if (cfg.enable && elapsed_q != 16'hFFFF) begin
							elapsed_q <= elapsed_q + 16'd1;
						end
						if (armed_q) begin
							cd_q <= cd_next;
							if (cd_next == 16'd0) begin
								armed_q     <= 1'b0;
								box_l_q     <= '0;
								box_t_q     <= '0;
								box_v_q     <= 1'b0;
								fill_q      <= '0;
								out_valid_q <= 1'b1;
								out_data_q  <= {4'd0, 15'd0, 15'd0, 14'd0, 14'd0, ST_LOST};
							end
						end
					end else if (q_pop) begin
						fill_q <= n_fill;
						if (elapsed_q > {3'd0, cfg.wticks}) begin
							n_q        <= n_fill;
							i_q        <= '0;
							best_cnt_q <= '0;
							best_key_q <= '0;
							state_q    <= S_LDI;
						end
					end
				end
				S_LDI: begin
					state_q <= S_LDW;
				end
				S_LDW: begin
					key_i_q <= key_rdata;
					j_q     <= '0;
					cnt_q   <= '0;
					lastj_q <= '0;
					state_q <= S_CNT;
				end
				S_CNT: begin
					if (last_j) begin
						if (better) begin
							best_cnt_q  <= c_fin;
							best_key_q  <= key_i_q;
							best_last_q <= lj;
						end
						i_q     <= i_q + CNT_W'(1);
						state_q <= (i_q + CNT_W'(1) == n_q) ? S_DEC : S_LDI;
					end else begin
						cnt_q   <= c_fin;
						lastj_q <= lj;
						j_q     <= j_q + WIN_AW'(1);
					end
				end
				S_DEC: begin
					if (fail) begin
						fill_q      <= '0;
						elapsed_q   <= '0;
						out_valid_q <= 1'b1;
						out_data_q  <= {4'd0, box_t_q, box_l_q, 14'd0, 14'd0, ST_NOTRK};
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_RW;
					end
				end
				S_RW: begin
					fill_q      <= '0;
					elapsed_q   <= '0;
					cd_q        <= (cfg.lost != 16'd0) ? cfg.lost : 16'd1;
					armed_q     <= 1'b1;
					out_valid_q <= 1'b1;
					if (in_box) begin
						out_data_q <= {4'd0, box_t_q, box_l_q, cy, cx, ST_INSIDE};
					end else begin
						box_l_q    <= nbx;
						box_t_q    <= nby;
						box_v_q    <= 1'b1;
						out_data_q <= {4'd0, nby, nbx, cy, cx, ST_MOVED};
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/windowed_mode_deadband_tracker_unit.sv
// Windowed mode dead-band tracker.
// Slave stream: one request per item; s_tuser is the action (0 detection,
// 1 millisecond tick), s_tdata carries face_key, rect_x, rect_y, rect_w and
// rect_h. Master stream: zero or one result per request, carrying status,
// target_x2, target_y2, box_x2 and box_y2.
// The APB port holds tracking_enable, window_ticks, pass_fraction_q8,
// box_size and lost_timeout_ticks at byte addresses 0, 4, 8, 12 and 16.
// A tick or a detection that does not close the window passes through the front
// queue and is handled by the back end in its idle state. A detection that closes
// a window runs a pairwise key count over its entries through the single read
// port of the key memory before its result is registered.
// A two-entry queue keeps accepting requests while the back end works or a
// result waits; when the receiver stalls the result is held in the output
// register and the back end waits, so the queue fills and s_tready drops.
// Reset clears the window, the box, the lost timer and the elapsed count and
// loads the register defaults; the window memories need no clearing.
`default_nettype none
module windowed_mode_deadband_tracker_unit
	import wmdt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// face_key, rect_x, rect_y, rect_w, rect_h, zero fill
	input  wire logic [IN_W-1:0]   s_tdata,
	// action
	input  wire logic              s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// status, target_x2, target_y2, box_x2, box_y2, zero fill
	output logic [OUT_W-1:0]       m_tdata,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	cfg_t        cfg_q;
	cfg_evt_t    evt;
	logic        wr;
	logic [2:0]  idx;
	logic        q_valid;
	item_t       q_item;
	logic        q_pop;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;

	// Side effects of a register write on the tracker state.
	always_comb begin
		evt.clear    = wr && (idx == REG_ENABLE) && (pwdata[0] != cfg_q.enable);
		evt.resize   = wr && (idx == REG_SIZE);
		evt.new_size = pwdata[7:0];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.wticks <= 13'd2000;
			cfg_q.pass   <= 9'd205;
			cfg_q.size   <= 8'd65;
			cfg_q.lost   <= 16'd750;
		end else if (wr) begin
			unique case (idx)
				REG_ENABLE: cfg_q.enable <= pwdata[0];
				REG_WTICKS: cfg_q.wticks <= pwdata[12:0];
				REG_PASS:   cfg_q.pass   <= pwdata[8:0];
				REG_SIZE:   cfg_q.size   <= pwdata[7:0];
				REG_LOST:   cfg_q.lost   <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (idx)
			REG_ENABLE: prdata = {31'd0, cfg_q.enable};
			REG_WTICKS: prdata = {19'd0, cfg_q.wticks};
			REG_PASS:   prdata = {23'd0, cfg_q.pass};
			REG_SIZE:   prdata = {24'd0, cfg_q.size};
			REG_LOST:   prdata = {16'd0, cfg_q.lost};
			default:    prdata = 32'd0;
		endcase
	end

	wmdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.enable   (cfg_q.enable),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	wmdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.cfg      (cfg_q),
		.evt      (evt),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

// File: verif/tracker_checker.sv
`timescale 1ns / 1ps
module tracker_checker
	import wmdt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,
	input  wire logic              s_tuser,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [OUT_W-1:0]  m_tdata,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	input  wire logic              pready,
	output int                     errors,
	output int                     pending,
	output int                     results
);

	typedef struct {
		logic [1:0]         status;
		logic [13:0]        tx;
		logic [13:0]        ty;
		logic signed [14:0] bx;
		logic signed [14:0] by;
	} track_res_t;

	// Shadow copy of the registers.
	logic        en_r;
	logic [12:0] wticks_r;
	logic [8:0]  pass_r;
	logic [7:0]  size_r;
	logic [15:0] lost_r;

	// Shadow copy of the window and tracking state.
	logic signed [KEY_BITS-1:0] win_key [WINDOW_DEPTH];
	logic [COORD_BITS-1:0]      win_x [WINDOW_DEPTH];
	logic [COORD_BITS-1:0]      win_y [WINDOW_DEPTH];
	logic [COORD_BITS-1:0]      win_w [WINDOW_DEPTH];
	logic [COORD_BITS-1:0]      win_h [WINDOW_DEPTH];
	int          fill;
	int          elapsed;
	int          box_l;
	int          box_t;
	bit          box_ok;
	int          lost_cnt;
	bit          lost_on;

	track_res_t  track_q[$];

	function automatic track_res_t make_res(logic [1:0] st, int tx, int ty);
		track_res_t r;
		r.status = st;
		r.tx = tx[13:0];
		r.ty = ty[13:0];
		r.bx = box_l[14:0];
		r.by = box_t[14:0];
		return r;
	endfunction

	function automatic int centre_of(int pos, int len);
		int c;
		c = 2 * pos + len;
		return (c > int'(CENTRE_MAX)) ? int'(CENTRE_MAX) : c;
	endfunction

	// Majority vote over the window, then the dead-band decision.
	function automatic track_res_t close_window();
		track_res_t r;
		int best_n, cnt, last, cx, cy, side;
		logic signed [KEY_BITS-1:0] best_k;
		best_n = 0;
		best_k = '0;
		last = 0;
		for (int i = 0; i < fill; i++) begin
			cnt = 0;
			for (int j = 0; j < fill; j++)
				if (win_key[j] == win_key[i])
					cnt++;
			if (cnt > best_n || (cnt == best_n && win_key[i] < best_k)) begin
				best_n = cnt;
				best_k = win_key[i];
			end
		end
		if (fill == 0 || best_k == -1 || best_n * 256 < int'(pass_r) * fill) begin
			r = make_res(ST_NOTRK, 0, 0);
		end else begin
			for (int i = 0; i < fill; i++)
				if (win_key[i] == best_k)
					last = i;
			cx = centre_of(int'(win_x[last]), int'(win_w[last]));
			cy = centre_of(int'(win_y[last]), int'(win_h[last]));
			side = box_ok ? 2 * int'(size_r) : 0;
			if (cx > box_l && cx < box_l + side && cy > box_t && cy < box_t + side) begin
				r = make_res(ST_INSIDE, cx, cy);
			end else begin
				box_l = cx - int'(size_r);
				box_t = cy - int'(size_r);
				box_ok = 1;
				r = make_res(ST_MOVED, cx, cy);
			end
			lost_cnt = (lost_r != 0) ? int'(lost_r) : 1;
			lost_on = 1;
		end
		fill = 0;
		elapsed = 0;
		return r;
	endfunction

	task automatic field_check(string nm, int e, int a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		track_res_t exp_r;
		if (!arst_n) begin
			en_r = 0;
			wticks_r = 13'd2000;
			pass_r = 9'd205;
			size_r = 8'd65;
			lost_r = 16'd750;
			fill = 0;
			elapsed = 0;
			box_l = 0;
			box_t = 0;
			box_ok = 0;
			lost_cnt = 0;
			lost_on = 0;
			track_q.delete();
			errors = 0;
			pending <= 0;
			results <= 0;
		end else begin
			// Compare each delivered result with the oldest prediction.
			if (m_tvalid && m_tready) begin
				results <= results + 1;
				if (track_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, m_tdata);
					errors++;
				end else begin
					exp_r = track_q.pop_front();
					field_check("status", int'(exp_r.status), int'(m_tdata[1:0]));
					field_check("target_x2", int'(exp_r.tx), int'(m_tdata[15:2]));
					field_check("target_y2", int'(exp_r.ty), int'(m_tdata[29:16]));
					field_check("box_x2", int'(exp_r.bx), int'($signed(m_tdata[44:30])));
					field_check("box_y2", int'(exp_r.by), int'($signed(m_tdata[59:45])));
				end
			end

			// Register writes.
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ENABLE: begin
						if (pwdata[0] != en_r) begin
							en_r = pwdata[0];
							fill = 0;
							elapsed = 0;
							box_l = 0;
							box_t = 0;
							box_ok = 0;
						end
					end
					REG_WTICKS: wticks_r = pwdata[12:0];
					REG_PASS: pass_r = pwdata[8:0];
					REG_SIZE: begin
						if (box_ok) begin
							box_l += int'(size_r) - int'(pwdata[7:0]);
							box_t += int'(size_r) - int'(pwdata[7:0]);
						end
						size_r = pwdata[7:0];
					end
					REG_LOST: lost_r = pwdata[15:0];
					default: ;
				endcase
			end

			// Requests: ticks run the counters, detections fill the window.
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser) == OP_TICK) begin
					if (en_r && elapsed < 65535)
						elapsed++;
					if (lost_on) begin
						if (lost_cnt > 0)
							lost_cnt--;
						if (lost_cnt == 0) begin
							lost_on = 0;
							box_l = 0;
							box_t = 0;
							box_ok = 0;
							fill = 0;
							exp_r = make_res(ST_LOST, 0, 0);
							track_q = {track_q, exp_r};
						end
					end
				end else if (en_r) begin
					if (fill < WINDOW_DEPTH) begin
						win_key[fill] = s_tdata[10:0];
						win_x[fill] = s_tdata[22:11];
						win_y[fill] = s_tdata[34:23];
						win_w[fill] = s_tdata[46:35];
						win_h[fill] = s_tdata[58:47];
						fill++;
					end
					if (elapsed > int'(wticks_r)) begin
						exp_r = close_window();
						track_q = {track_q, exp_r};
					end
				end
			end
			pending <= track_q.size();
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import wmdt_pkg::*;

	localparam int IDLE_LIMIT = 40000;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              s_tvalid = 0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              s_tuser = 0;
	logic              m_tvalid;
	logic              m_tready = 0;
	logic [OUT_W-1:0]  m_tdata;
	logic              psel = 0;
	logic              penable = 0;
	logic              pwrite = 0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	int                errors;
	int                pending;
	int                results;

	// Sender and receiver control.
	int  burst_left = 0;
	bit  no_gaps = 0;
	bit  hold_req = 0;
	int  hold_left = 0;
	int  rx_cyc = 0;
	int  rx_mode = 0;
	int  idle_cyc = 0;
	int  sent = 0;
	int  wt_cur = 2000;
	bit  en_cur = 0;
	int  base_x, base_y, base_w, base_h;

	windowed_mode_deadband_tracker_unit dut (.*);

	tracker_checker chk (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Receiver: changing stall patterns, plus one long hold on request.
	always @(posedge clk) begin
		rx_cyc++;
		if (rx_cyc % 400 == 0)
			rx_mode = $urandom_range(0, 2);
		if (hold_req) begin
			hold_left = 3000;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1;
				1: m_tready <= (rx_cyc % 9) < 6;
				default: m_tready <= $urandom_range(0, 3) != 0;
			endcase
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Registers are written only once the block has gone quiet.
	task automatic reg_write(logic [2:0] idx, int val);
		drain();
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
		if (idx == REG_WTICKS)
			wt_cur = val;
		if (idx == REG_ENABLE)
			en_cur = val[0];
	endtask

	task automatic send(op_t op, logic signed [10:0] key, int x, int y, int w, int h);
		int gap;
		if (burst_left == 0) begin
			if (!no_gaps) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {5'b0, h[11:0], w[11:0], y[11:0], x[11:0], key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic tick();
		send(OP_TICK, 11'($urandom_range(0, 2047)), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
	endtask

	function automatic logic signed [10:0] pick_key();
		case ($urandom_range(0, 5))
			0: return -11'sd1;
			1: return 11'sd1023;
			2: return 11'sd0;
			3: return 11'($urandom_range(0, 1023));
			default: return 11'($urandom_range(0, 3));
		endcase
	endfunction

	// Detection rectangles mostly jitter around a base so boxes get hit.
	task automatic detect(logic signed [10:0] key);
		if ($urandom_range(0, 4) == 0)
			send(OP_DET, key, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095));
		else
			send(OP_DET, key, base_x + $urandom_range(0, 6), base_y + $urandom_range(0, 6),
				base_w + $urandom_range(0, 6), base_h + $urandom_range(0, 6));
	endtask

	task automatic new_base();
		base_x = $urandom_range(0, 4089);
		base_y = $urandom_range(0, 4089);
		base_w = $urandom_range(0, 4089);
		base_h = $urandom_range(0, 4089);
	endtask

	// One window: detections spread over ticks, then the closing detection.
	task automatic run_window(int nd, int share, logic signed [10:0] wkey);
		int ticks;
		ticks = 0;
		for (int i = 0; i < nd - 1; i++) begin
			detect(($urandom_range(0, 99) < share) ? wkey : pick_key());
			repeat ($urandom_range(0, 3)) begin
				if (ticks < wt_cur) begin
					tick();
					ticks++;
				end
			end
		end
		while (ticks <= wt_cur + $urandom_range(0, 2)) begin
			tick();
			ticks++;
		end
		detect(wkey);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic fixed_rect_window(int x, int y);
		repeat (wt_cur + 1) tick();
		send(OP_DET, 11'sd5, x, y, 0, 0);
	endtask

	initial begin
		bit did_long;
		int nd;
		did_long = 0;
		new_base();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, box edge, inside, not tracked, full window.
		reg_write(REG_ENABLE, 1);
		reg_write(REG_WTICKS, 4);
		reg_write(REG_PASS, 256);
		reg_write(REG_SIZE, 150);
		reg_write(REG_LOST, 65535);
		send(OP_DET, 11'sd1023, 4095, 4095, 4095, 4095);
		send(OP_DET, -11'sd1, 0, 0, 0, 0);
		fixed_rect_window(100, 100);
		fixed_rect_window(100, 100);
		fixed_rect_window(250, 100);
		fixed_rect_window(260, 110);
		run_window(4, 100, -11'sd1);
		repeat (wt_cur + 1) tick();
		send(OP_DET, 11'sd1023, 4095, 4095, 4095, 4095);
		run_window(70, 100, 11'sd2);
		drain();
		reg_write(REG_SIZE, 5);
		reg_write(REG_PASS, 0);
		reg_write(REG_ENABLE, 0);
		send(OP_DET, 11'sd3, 1, 2, 3, 4);
		repeat (5) tick();
		reg_write(REG_ENABLE, 1);
		reg_write(REG_LOST, 1);
		run_window(3, 50, 11'sd0);
		repeat (3) tick();
		drain();

		// Pressure: receiver holds off while windows keep coming.
		reg_write(REG_WTICKS, 4);
		reg_write(REG_LOST, 1);
		no_gaps = 1;
		hold_req = 1;
		repeat (6) run_window(1, 100, 11'sd7);
		no_gaps = 0;
		drain();

		// Random phases with changing settings.
		while (sent < 650) begin
			if ($urandom_range(0, 5) == 0)
				reg_write(REG_ENABLE, int'(!en_cur));
			if (!did_long && results > 20) begin
				reg_write(REG_WTICKS, 200);
				did_long = 1;
			end else begin
				reg_write(REG_WTICKS, ($urandom_range(0, 2) == 0) ?
					$urandom_range(0, 12) : 4);
			end
			case ($urandom_range(0, 2))
				0: reg_write(REG_PASS, 0);
				1: reg_write(REG_PASS, 256);
				default: reg_write(REG_PASS, $urandom_range(0, 256));
			endcase
			case ($urandom_range(0, 2))
				0: reg_write(REG_SIZE, 5);
				1: reg_write(REG_SIZE, 150);
				default: reg_write(REG_SIZE, $urandom_range(5, 150));
			endcase
			case ($urandom_range(0, 3))
				0: reg_write(REG_LOST, 1);
				1: reg_write(REG_LOST, 65535);
				default: reg_write(REG_LOST, $urandom_range(1, 400));
			endcase
			repeat ($urandom_range(2, 4)) begin
				if ($urandom_range(0, 3) == 0)
					new_base();
				nd = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 70) :
					$urandom_range(1, 8);
				run_window(nd, $urandom_range(30, 100), pick_key());
				repeat ($urandom_range(0, 20)) tick();
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
